// ===== rtl/core/lfs_pkg.sv =====
// Package for the Lambert face shading block: payload structs, sizes,
// register indexes, sequencer states and small helpers.
// No dependencies.
package lfs_pkg;

  localparam int VEC_W   = 25;   // light vector component, signed
  localparam int SQ_W    = 52;   // sum of squares / square root working width
  localparam int SUB_W   = 53;   // shared subtractor width
  localparam int LEN_W   = 26;   // vector length
  localparam int UNIT_W  = 17;   // signed Q1.15 unit component
  localparam int MUL_W   = 26;   // multiplier operand width, signed
  localparam int PROD_W  = 2 * MUL_W;
  localparam int SUM_W   = 24;
  localparam int VCNT_W  = 8;
  localparam int CH_W    = 16;
  localparam int STEP_W  = 5;

  localparam int SQRT_STEPS = 26;
  localparam int DIV_STEPS  = 16;
  localparam int AVG_STEPS  = SUM_W;
  localparam int VEC_TERMS  = 3;

  localparam logic [VCNT_W-1:0] MAX_FACE_VERTICES = 8'd255;

  localparam logic [23:0] LIGHT_RESET   = 24'd153600;
  localparam logic [47:0] DIFFUSE_RESET = 48'd56294995342131;
  localparam logic [47:0] AMBIENT_RESET = 48'd14074822593741;

  typedef enum logic [2:0] {
    REG_LIGHT_X     = 3'd0,
    REG_LIGHT_Y     = 3'd1,
    REG_LIGHT_Z     = 3'd2,
    REG_DIFFUSE_RGB = 3'd3,
    REG_AMBIENT_RGB = 3'd4
  } lfs_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_SQRT,
    ST_DIV,
    ST_DOT,
    ST_AVG,
    ST_CHAN
  } lfs_state_t;

  typedef struct packed {
    logic signed [23:0] vertex_x;
    logic signed [23:0] vertex_y;
    logic signed [23:0] vertex_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               last_of_face;
  } lfs_in_t;

  typedef struct packed {
    logic [15:0] color_red;
    logic [15:0] color_green;
    logic [15:0] color_blue;
    logic [7:0]  vertices_used;
    logic        too_many_vertices;
  } lfs_out_t;

  // diffuse * mean >> 16, plus ambient, capped at full scale
  function automatic logic [CH_W-1:0] chan_sat(input logic [PROD_W-1:0] prod,
                                               input logic [CH_W-1:0] amb);
    logic [CH_W:0] s;
    s = {1'b0, prod[2*CH_W-1:CH_W]} + {1'b0, amb};
    return s[CH_W] ? {CH_W{1'b1}} : s[CH_W-1:0];
  endfunction

endpackage

// ===== rtl/core/lambert_face_shading.sv =====
// Lambert face shading: one vertex an item, one colour per face, on one shared
// multiplier and one shared subtractor under a sequencer. Uses lfs_pkg.
// A face's colour follows its last vertex after two vectors (light, then normal) each pass
// square, root and divide steps, then the dot step, then the mean and colour steps.
// A new vertex is taken only when idle, after the last one is done; a vertex beyond the
// limit is not shaded. Synchronous reset (rst_n low) clears face state and out_valid.
module lambert_face_shading (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lfs_pkg::lfs_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lfs_pkg::lfs_out_t  out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_data
);
  import lfs_pkg::*;

  lfs_state_t state_r, state_nxt;

  logic signed [23:0] light_x_r, light_y_r, light_z_r;
  logic [47:0]        diffuse_r, ambient_r;

  logic [STEP_W-1:0]  cnt_r;
  logic [1:0]         ci_r;
  logic               vsel_r;
  logic               last_r;
  logic [SUM_W-1:0]   sum_r;
  logic [VCNT_W-1:0]  vcount_r;
  logic               ovf_r;
  logic               out_valid_r;
  lfs_out_t           out_r;

  logic signed [VEC_W-1:0]  lvec_r [VEC_TERMS];
  logic signed [VEC_W-1:0]  nvec_r [VEC_TERMS];
  logic signed [UNIT_W-1:0] uvl_r  [VEC_TERMS];
  logic signed [UNIT_W-1:0] uvn_r  [VEC_TERMS];

  logic signed [PROD_W-1:0] prod_r, acc_r;
  logic [SQ_W-1:0]    x_r, r_r;
  logic [LEN_W-1:0]   len_r, rem_r;
  logic [DIV_STEPS-1:0] q_r;
  logic [SUM_W-1:0]   qa_r;
  logic [CH_W-1:0]    mean_r;
  logic [CH_W-1:0]    col0_r, col1_r;

  // shared units
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [SUB_W-1:0]   sub_a, sub_b, sub_d;
  logic               sub_ge;

  logic [1:0]               vidx;
  logic signed [VEC_W-1:0]  cur_v;
  logic                     cur_neg;
  logic [VEC_W-1:0]         cur_abs;
  logic [LEN_W:0]           rem_cur;
  logic [SQ_W-1:0]          bit_b, r_step;
  logic [5:0]               b_shift;
  logic [DIV_STEPS-1:0]     q_nxt;
  logic signed [UNIT_W-1:0] unit_val;
  logic signed [PROD_W-1:0] dot_sum;
  logic [CH_W-1:0]          inten;
  logic [SUM_W-1:0]         sum_new;
  logic [SUM_W-1:0]         qa_nxt;
  logic                     stall;
  logic                     full_face;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign stall     = out_valid_r && !out_ready;
  assign full_face = (vcount_r >= MAX_FACE_VERTICES);
  assign vidx      = (cnt_r[1:0] == 2'd3) ? 2'd0 : cnt_r[1:0];

  // operand selection for the divide and square root steps
  always_comb begin
    cur_v   = vsel_r ? nvec_r[ci_r] : lvec_r[ci_r];
    cur_neg = cur_v[VEC_W-1];
    cur_abs = cur_neg ? VEC_W'(-cur_v) : VEC_W'(cur_v);
    rem_cur = (cnt_r == '0) ? (LEN_W+1)'(cur_abs) : {rem_r, 1'b0};
    b_shift = 6'(2 * (SQRT_STEPS - 1)) - {cnt_r, 1'b0};
    bit_b   = SQ_W'(1) << b_shift;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_SQ: begin
        mul_a = MUL_W'(vsel_r ? nvec_r[vidx] : lvec_r[vidx]);
        mul_b = mul_a;
      end
      ST_DOT: begin
        mul_a = MUL_W'(uvl_r[vidx]);
        mul_b = MUL_W'(uvn_r[vidx]);
      end
      ST_CHAN: begin
        mul_a = $signed({{(MUL_W-CH_W){1'b0}}, diffuse_r[CH_W*vidx +: CH_W]});
        mul_b = $signed({{(MUL_W-CH_W){1'b0}}, mean_r});
      end
      default: ;
    endcase
    prod = mul_a * mul_b;
  end

  always_comb begin
    sub_a = '0;
    sub_b = '0;
    case (state_r)
      ST_SQRT: begin
        sub_a = SUB_W'(x_r);
        sub_b = SUB_W'(r_r) + SUB_W'(bit_b);
      end
      ST_DIV: begin
        sub_a = SUB_W'(rem_cur);
        sub_b = SUB_W'(len_r);
      end
      ST_AVG: begin
        sub_a = SUB_W'({rem_r[VCNT_W-1:0], qa_r[SUM_W-1]});
        sub_b = SUB_W'(vcount_r);
      end
      default: ;
    endcase
    sub_d  = sub_a - sub_b;
    sub_ge = ~sub_d[SUB_W-1];
  end

  always_comb begin
    r_step   = sub_ge ? ((r_r >> 1) + bit_b) : (r_r >> 1);
    q_nxt    = {q_r[DIV_STEPS-2:0], sub_ge};
    unit_val = (len_r == '0) ? '0 :
               (cur_neg ? -$signed({1'b0, q_nxt}) : $signed({1'b0, q_nxt}));
    dot_sum  = acc_r + prod_r;
    // clamp at zero, drop 14 fraction bits, cap at full scale
    if (dot_sum <= 0)
      inten = '0;
    else if (dot_sum[PROD_W-1:CH_W+14] != '0)
      inten = {CH_W{1'b1}};
    else
      inten = dot_sum[CH_W+13:14];
    sum_new = sum_r + SUM_W'(inten);
    qa_nxt  = {qa_r[SUM_W-2:0], sub_ge};
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (!full_face)
            state_nxt = ST_SQ;
          else if (in_data.last_of_face)
            state_nxt = ST_AVG;
        end
      end
      ST_SQ:   if (cnt_r == STEP_W'(VEC_TERMS)) state_nxt = ST_SQRT;
      ST_SQRT: if (cnt_r == STEP_W'(SQRT_STEPS - 1)) state_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == STEP_W'(DIV_STEPS - 1) && ci_r == 2'(VEC_TERMS - 1))
          state_nxt = vsel_r ? ST_DOT : ST_SQ;
      end
      ST_DOT: begin
        if (cnt_r == STEP_W'(VEC_TERMS))
          state_nxt = last_r ? ST_AVG : ST_IDLE;
      end
      ST_AVG:  if (cnt_r == STEP_W'(AVG_STEPS - 1)) state_nxt = ST_CHAN;
      ST_CHAN: if (cnt_r == STEP_W'(VEC_TERMS) && !stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      ci_r        <= '0;
      vsel_r      <= 1'b0;
      last_r      <= 1'b0;
      sum_r       <= '0;
      vcount_r    <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      light_x_r   <= LIGHT_RESET;
      light_y_r   <= LIGHT_RESET;
      light_z_r   <= LIGHT_RESET;
      diffuse_r   <= DIFFUSE_RESET;
      ambient_r   <= AMBIENT_RESET;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid) begin
        unique case (cfg_index)
          REG_LIGHT_X:     light_x_r <= cfg_data[23:0];
          REG_LIGHT_Y:     light_y_r <= cfg_data[23:0];
          REG_LIGHT_Z:     light_z_r <= cfg_data[23:0];
          REG_DIFFUSE_RGB: diffuse_r <= cfg_data;
          REG_AMBIENT_RGB: ambient_r <= cfg_data;
          default: ;
        endcase
      end

      // raise on a new colour, drop once the waiting item is taken
      if (state_r == ST_CHAN && cnt_r == STEP_W'(VEC_TERMS) && !stall)
        out_valid_r <= 1'b1;
      else if (out_ready)
        out_valid_r <= 1'b0;

      if (state_r == ST_CHAN && stall && cnt_r == STEP_W'(VEC_TERMS))
        cnt_r <= cnt_r;
      else if (state_nxt != state_r ||
               (state_r == ST_DIV && cnt_r == STEP_W'(DIV_STEPS - 1)))
        cnt_r <= '0;
      else
        cnt_r <= cnt_r + 1'b1;

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            last_r <= in_data.last_of_face;
            rem_r  <= '0;
            qa_r   <= sum_r;
            vsel_r <= 1'b0;
            ci_r   <= '0;
            if (full_face) begin
              ovf_r <= 1'b1;
            end else begin
              lvec_r[0] <= VEC_W'(light_x_r) - VEC_W'(in_data.vertex_x);
              lvec_r[1] <= VEC_W'(light_y_r) - VEC_W'(in_data.vertex_y);
              lvec_r[2] <= VEC_W'(light_z_r) - VEC_W'(in_data.vertex_z);
              nvec_r[0] <= VEC_W'(in_data.normal_x);
              nvec_r[1] <= VEC_W'(in_data.normal_y);
              nvec_r[2] <= VEC_W'(in_data.normal_z);
            end
          end
        end
        ST_SQ, ST_DOT: begin
          if (cnt_r != STEP_W'(VEC_TERMS)) prod_r <= prod;
          if (cnt_r == STEP_W'(1)) acc_r <= prod_r;
          else if (cnt_r != '0) acc_r <= acc_r + prod_r;
          if (cnt_r == STEP_W'(VEC_TERMS)) begin
            if (state_r == ST_SQ) begin
              x_r <= SQ_W'(dot_sum);
              r_r <= '0;
            end else begin
              sum_r    <= sum_new;
              vcount_r <= vcount_r + 1'b1;
              qa_r     <= sum_new;
              rem_r    <= '0;
            end
          end
        end
        ST_SQRT: begin
          if (sub_ge) x_r <= sub_d[SQ_W-1:0];
          r_r <= r_step;
          if (cnt_r == STEP_W'(SQRT_STEPS - 1)) begin
            len_r <= r_step[LEN_W-1:0];
            ci_r  <= '0;
          end
        end
        ST_DIV: begin
          rem_r <= sub_ge ? sub_d[LEN_W-1:0] : rem_cur[LEN_W-1:0];
          q_r   <= q_nxt;
          if (cnt_r == STEP_W'(DIV_STEPS - 1)) begin
            if (vsel_r) uvn_r[ci_r] <= unit_val;
            else        uvl_r[ci_r] <= unit_val;
            if (ci_r == 2'(VEC_TERMS - 1)) begin
              ci_r   <= '0;
              vsel_r <= 1'b1;
            end else begin
              ci_r <= ci_r + 1'b1;
            end
          end
        end
        ST_AVG: begin
          rem_r <= sub_ge ? LEN_W'(sub_d[VCNT_W:0]) : LEN_W'(sub_a[VCNT_W:0]);
          qa_r  <= qa_nxt;
          if (cnt_r == STEP_W'(AVG_STEPS - 1))
            mean_r <= (vcount_r == '0) ? '0 : qa_nxt[CH_W-1:0];
        end
        ST_CHAN: begin
          if (cnt_r != STEP_W'(VEC_TERMS)) prod_r <= prod;
          if (cnt_r == STEP_W'(1)) col0_r <= chan_sat(prod_r, ambient_r[15:0]);
          if (cnt_r == STEP_W'(2)) col1_r <= chan_sat(prod_r, ambient_r[31:16]);
          if (cnt_r == STEP_W'(VEC_TERMS) && !stall) begin
            out_r.color_red         <= col0_r;
            out_r.color_green       <= col1_r;
            out_r.color_blue        <= chan_sat(prod_r, ambient_r[47:32]);
            out_r.vertices_used     <= vcount_r;
            out_r.too_many_vertices <= ovf_r;
            // start the next face
            sum_r    <= '0;
            vcount_r <= '0;
            ovf_r    <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/lfs_checker.sv =====
// Port-level checks for lambert_face_shading, bound to the top level.
// Uses lfs_pkg for the payload structs.
module lfs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input lfs_pkg::lfs_in_t   in_data,
  input logic               out_valid,
  input logic               out_ready,
  input lfs_pkg::lfs_out_t  out_data
);
  import lfs_pkg::*;

  // a stalled result item stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result item changed while stalled");

  // every face reports at least one vertex
  a_used_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.vertices_used != 8'd0)
    else $error("face emitted with no vertices");

  // a face's last vertex always keeps the block busy for a while
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.last_of_face |=> !in_ready)
    else $error("ready straight after a last vertex");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind lambert_face_shading lfs_checker u_lfs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/tb_lambert_face_shading.sv =====
// Testbench for lambert_face_shading: drives vertices, predicts each face colour
// with a local integer model of the shading arithmetic and checks every result.
// Depends on lfs_pkg and the lambert_face_shading RTL.
`timescale 1ns / 100ps

module tb_lambert_face_shading;
  import lfs_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  lfs_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  lfs_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [47:0] cfg_data = '0;

  lambert_face_shading DUT (.*);

  always #2 clk = ~clk;

  // local copy of configuration and face state
  logic signed [23:0] lx, ly, lz;
  logic [47:0] diff_rgb, amb_rgb;
  logic [23:0] isum;
  logic [7:0] vcount;
  logic ovf;
  lfs_out_t colour_q[$];
  int fails = 0;
  longint cycles = 0;
  int stall_mode = 0;   // 0 random, 1 never stall, 2 hold off
  int hold_cycles = 0;
  int gap_max = 4;

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void to_unit(input longint v[3], output longint u[3]);
    longint unsigned sq, len, a;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      a = v[i] < 0 ? -v[i] : v[i];
      sq += a * a;
    end
    len = isqrt(sq);
    for (int i = 0; i < 3; i++) begin
      a = v[i] < 0 ? -v[i] : v[i];
      if (len == 0) u[i] = 0;
      else begin
        u[i] = longint'((a << 15) / len);
        if (v[i] < 0) u[i] = -u[i];
      end
    end
  endfunction

  function automatic logic [15:0] lambert_of(lfs_in_t v);
    longint l[3], n[3], ul[3], un[3], d;
    l[0] = longint'(lx) - longint'(v.vertex_x);
    l[1] = longint'(ly) - longint'(v.vertex_y);
    l[2] = longint'(lz) - longint'(v.vertex_z);
    n[0] = v.normal_x;
    n[1] = v.normal_y;
    n[2] = v.normal_z;
    to_unit(l, ul);
    to_unit(n, un);
    d = ul[0] * un[0] + ul[1] * un[1] + ul[2] * un[2];
    if (d <= 0) return 16'd0;
    d = d >>> 14;
    return d > 65535 ? 16'hFFFF : d[15:0];
  endfunction

  // advance the face state; queue a colour on the face's last vertex
  task automatic shade_vertex(lfs_in_t v);
    lfs_out_t r;
    longint unsigned mean, c;
    if (vcount < MAX_FACE_VERTICES) begin
      isum = isum + lambert_of(v);
      vcount = vcount + 8'd1;
    end else ovf = 1'b1;
    if (v.last_of_face) begin
      mean = vcount != 0 ? isum / vcount : 0;
      for (int k = 0; k < 3; k++) begin
        c = ((longint'(diff_rgb[16*k +: 16]) * mean) >> 16) + amb_rgb[16*k +: 16];
        if (c > 65535) c = 65535;
        if (k == 0) r.color_red = c[15:0];
        else if (k == 1) r.color_green = c[15:0];
        else r.color_blue = c[15:0];
      end
      r.vertices_used = vcount;
      r.too_many_vertices = ovf;
      colour_q.insert(colour_q.size(), r);
      isum = '0;
      vcount = '0;
      ovf = 1'b0;
    end
  endtask

  // valid stays up for a following item; gaps and drains drop it
  task automatic send_vertex(lfs_in_t v);
    in_data <= v;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    shade_vertex(v);
    @(negedge clk);
  endtask

  // bursts with random gaps between them
  int burst_left = 0;
  task automatic paced_vertex(lfs_in_t v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    send_vertex(v);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (colour_q.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic write_reg(lfs_reg_t idx, logic [47:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_LIGHT_X: lx = val[23:0];
      REG_LIGHT_Y: ly = val[23:0];
      REG_LIGHT_Z: lz = val[23:0];
      REG_DIFFUSE_RGB: diff_rgb = val;
      REG_AMBIENT_RGB: amb_rgb = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_bad_index(logic [2:0] idx);
    cfg_index <= idx;
    cfg_data <= 48'({$urandom, $urandom});
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic lfs_in_t rand_vertex(logic last);
    lfs_in_t v;
    v.vertex_x = 24'($urandom);
    v.vertex_y = 24'($urandom);
    v.vertex_z = 24'($urandom);
    v.normal_x = 16'($urandom);
    v.normal_y = 16'($urandom);
    v.normal_z = 16'($urandom);
    // mostly modest coordinates so the light direction varies
    if ($urandom_range(0, 3) != 0) begin
      v.vertex_x = $signed(v.vertex_x) >>> $urandom_range(0, 12);
      v.vertex_y = $signed(v.vertex_y) >>> $urandom_range(0, 12);
      v.vertex_z = $signed(v.vertex_z) >>> $urandom_range(0, 12);
    end
    v.last_of_face = last;
    return v;
  endfunction

  function automatic lfs_in_t mk(int x, int y, int z, int nx, int ny, int nz, logic last);
    lfs_in_t v;
    v.vertex_x = 24'(x);
    v.vertex_y = 24'(y);
    v.vertex_z = 24'(z);
    v.normal_x = 16'(nx);
    v.normal_y = 16'(ny);
    v.normal_z = 16'(nz);
    v.last_of_face = last;
    return v;
  endfunction

  task automatic test_directed();
    send_vertex(mk(0, 0, 0, 1, 1, 1, 1'b1));
    send_vertex(mk(0, 0, 0, 0, 0, 0, 1'b1));                // zero normal
    send_vertex(mk(153600, 153600, 153600, 5, 5, 5, 1'b1)); // vertex at the light
    send_vertex(mk(-8388608, -8388608, -8388608, 32767, 32767, 32767, 1'b0));
    send_vertex(mk(8388607, 8388607, 8388607, -32768, -32768, -32768, 1'b1));
    send_vertex(mk(100, -200, 300, -1, -1, -1, 1'b0));      // facing away
    send_vertex(mk(0, 0, 0, 32767, 0, 0, 1'b1));
    send_vertex(mk(1, 2, 3, 0, 0, 32767, 1'b0));
    send_vertex(mk(4, 5, 6, 0, -32768, 0, 1'b0));
    send_vertex(mk(7, 8, 9, 3, 4, 5, 1'b1));
    drain();
  endtask

  task automatic test_registers();
    write_reg(REG_LIGHT_X, 48'h7FFFFF);
    write_reg(REG_LIGHT_Y, 48'h800000);
    write_reg(REG_LIGHT_Z, 48'h000000);
    write_reg(REG_DIFFUSE_RGB, 48'hFFFF_FFFF_FFFF);
    write_reg(REG_AMBIENT_RGB, 48'hFFFF_FFFF_FFFF);
    write_bad_index(3'd5);
    write_bad_index(3'd7);
    send_vertex(mk(0, 0, 0, 32767, -32768, 1, 1'b1));
    send_vertex(mk(-5000, 9000, -1, 1, 1, 1, 1'b1));
    drain();
    write_reg(REG_DIFFUSE_RGB, 48'h0);
    write_reg(REG_AMBIENT_RGB, 48'h0);
    send_vertex(mk(0, 0, 0, 1, 0, 0, 1'b1));
    drain();
  endtask

  task automatic test_long_face();
    write_reg(REG_DIFFUSE_RGB, 48'h4000_4000_4000);
    write_reg(REG_AMBIENT_RGB, 48'h0100_0200_0300);
    for (int i = 0; i < 258; i++) paced_vertex(rand_vertex(i == 257));
    drain();
  endtask

  task automatic test_random(int n);
    int left, len;
    left = n;
    while (left > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        drain();
        write_reg(REG_LIGHT_X, 48'({$urandom, $urandom}));
        write_reg(REG_LIGHT_Y, 48'({$urandom, $urandom} >> $urandom_range(0, 12)));
        write_reg(REG_LIGHT_Z, 48'({$urandom, $urandom}));
        write_reg(REG_DIFFUSE_RGB, 48'({$urandom, $urandom}));
        write_reg(REG_AMBIENT_RGB, 48'({$urandom, $urandom}) & 48'h3FFF_3FFF_3FFF);
      end
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) paced_vertex(rand_vertex(i == len - 1));
      left -= len;
    end
    drain();
  endtask

  task automatic test_pressure();
    stall_mode = 2;
    hold_cycles = 3000;
    for (int i = 0; i < 12; i++) send_vertex(rand_vertex(1'b1));
    drain();
    stall_mode = 1;
    gap_max = 0;
    for (int i = 0; i < 30; i++) paced_vertex(rand_vertex(1'($urandom_range(0, 1))));
    paced_vertex(rand_vertex(1'b1));
    drain();
    stall_mode = 0;
    gap_max = 4;
  endtask

  // receiver: random stalls, or a long counted hold-off
  always @(negedge clk) begin
    if (stall_mode == 2) begin
      out_ready <= 1'b0;
      if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
      else stall_mode <= 1;
    end else if (stall_mode == 1) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    lfs_out_t exp_c;
    if (rst_n && out_valid && out_ready) begin
      if (colour_q.size() == 0) begin
        $error("colour with no face pending");
        fails++;
      end else begin
        exp_c = colour_q.pop_front();
        if (out_data.color_red !== exp_c.color_red) begin
          $error("color_red exp %0d got %0d", exp_c.color_red, out_data.color_red);
          fails++;
        end
        if (out_data.color_green !== exp_c.color_green) begin
          $error("color_green exp %0d got %0d", exp_c.color_green, out_data.color_green);
          fails++;
        end
        if (out_data.color_blue !== exp_c.color_blue) begin
          $error("color_blue exp %0d got %0d", exp_c.color_blue, out_data.color_blue);
          fails++;
        end
        if (out_data.vertices_used !== exp_c.vertices_used) begin
          $error("vertices_used exp %0d got %0d", exp_c.vertices_used,
                 out_data.vertices_used);
          fails++;
        end
        if (out_data.too_many_vertices !== exp_c.too_many_vertices) begin
          $error("too_many_vertices exp %0d got %0d", exp_c.too_many_vertices,
                 out_data.too_many_vertices);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("lambert_face_shading regression: fail");
      $finish;
    end
  end

  initial begin
    lx = LIGHT_RESET;
    ly = LIGHT_RESET;
    lz = LIGHT_RESET;
    diff_rgb = DIFFUSE_RESET;
    amb_rgb = AMBIENT_RESET;
    isum = '0;
    vcount = '0;
    ovf = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_registers();
    test_long_face();
    test_pressure();
    test_random(1100);
    if (fails == 0 && colour_q.size() == 0) $display("lambert_face_shading regression: pass");
    else $display("lambert_face_shading regression: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/lfs_pkg.sv
rtl/core/lambert_face_shading.sv
rtl/core/lfs_checker.sv
tb/tb_lambert_face_shading.sv
